@@ sv/scd_pkg.sv @@
// Shared types and constants for the scribble cross-out detector.
`timescale 1ns / 1ps

package scd_pkg;

   localparam int COORD_W  = 20;
   localparam int POINT_W  = 2 * COORD_W;
   localparam int REVS_W   = 10;
   localparam int MUL_B_W  = 12;
   localparam int MUL_P_W  = COORD_W + MUL_B_W;
   localparam int RATIO_W  = 8;
   localparam int THR_W    = COORD_W + RATIO_W;
   localparam int MINPTS_W = 11;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   localparam logic [REVS_W-1:0] REVS_MAX = '1;

   // register reset values
   localparam logic [10:0] RST_MIN_POINTS     = 11'd12;
   localparam logic [19:0] RST_MIN_LONG_SIDE  = 20'd384;
   localparam logic [7:0]  RST_BLOB_RATIO     = 8'd192;
   localparam logic [19:0] RST_NOISE_FLOOR    = 20'd48;
   localparam logic [7:0]  RST_NOISE_FRACTION = 8'd13;
   localparam logic [9:0]  RST_MIN_REVERSALS  = 10'd4;
   localparam logic [11:0] RST_TRAVEL_FACTOR  = 12'd563;

   typedef enum logic [2:0] {
      REG_MIN_POINTS     = 3'd0,
      REG_MIN_LONG_SIDE  = 3'd1,
      REG_BLOB_RATIO     = 3'd2,
      REG_NOISE_FLOOR    = 3'd3,
      REG_NOISE_FRACTION = 3'd4,
      REG_MIN_REVERSALS  = 3'd5,
      REG_TRAVEL_FACTOR  = 3'd6
   } scd_reg_type;

   // shared multiplier step
   typedef enum logic [1:0] {
      MUL_BLOB   = 2'd0,
      MUL_NOISE  = 2'd1,
      MUL_TRAVEL = 2'd2
   } scd_mul_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_BOX   = 8'b0000_0010,
      S_MUL   = 8'b0000_0100,
      S_CHECK = 8'b0000_1000,
      S_FETCH = 8'b0001_0000,
      S_DIFF  = 8'b0010_0000,
      S_UPD   = 8'b0100_0000,
      S_FINAL = 8'b1000_0000
   } scd_state_type;

endpackage

@@ sv/scd_req_if.sv @@
// Request channel: one pen point per request.
`timescale 1ns / 1ps

interface scd_req_if;
   logic                    valid;
   logic                    ready;
   logic signed [19:0]      x_coord;
   logic signed [19:0]      y_coord;
   logic                    last_point;

   modport source (output valid, x_coord, y_coord, last_point, input ready);
   modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

@@ sv/scd_rsp_if.sv @@
// Response channel: one verdict per stroke.
`timescale 1ns / 1ps

interface scd_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    is_scribble;
   logic [9:0]              reversal_count;
   logic                    overflow;

   modport source (output valid, is_scribble, reversal_count, overflow, input ready);
   modport sink   (input valid, is_scribble, reversal_count, overflow, output ready);
endinterface

@@ sv/scribble_crossout_detector.sv @@
// Scribble cross-out detector: point store, bounding box and reversal pass.
`timescale 1ns / 1ps
// Loading: one point per cycle, ready whenever the sequencer is idle.
// After the last point: box step, blob/noise/travel multiplies, check, then final
// state for a rejected or single-point stroke; else a fetch, then per further
// point a difference and an update step: one read port, one shared diff unit.
// Verdict sits in an output register; the next stroke loads while it waits.
// Synchronous active-high reset restores register defaults; no clearing pass.

module scribble_crossout_detector #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   scd_req_if.sink                       req_chan,
   scd_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [scd_pkg::ADDR_W-1:0]    paddr,
   input  logic [scd_pkg::DATA_W-1:0]    pwdata,
   output logic [scd_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int CMPW = (CW > scd_pkg::MINPTS_W) ? CW : scd_pkg::MINPTS_W;
   localparam int TW   = scd_pkg::COORD_W + CW;       // travel accumulator
   localparam int TCW  = TW + scd_pkg::RATIO_W;       // travel scaled by 256
   localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

   // ---------------------------------------------------------------- config
   logic [10:0] min_points_ff;
   logic [19:0] min_long_side_ff;
   logic [7:0]  blob_ratio_ff;
   logic [19:0] noise_floor_ff;
   logic [7:0]  noise_fraction_ff;
   logic [9:0]  min_reversals_ff;
   logic [11:0] travel_factor_ff;

   scd_pkg::scd_reg_type reg_sel;
   logic                 csr_write;

   assign reg_sel   = scd_pkg::scd_reg_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_points_ff     <= scd_pkg::RST_MIN_POINTS;
         min_long_side_ff  <= scd_pkg::RST_MIN_LONG_SIDE;
         blob_ratio_ff     <= scd_pkg::RST_BLOB_RATIO;
         noise_floor_ff    <= scd_pkg::RST_NOISE_FLOOR;
         noise_fraction_ff <= scd_pkg::RST_NOISE_FRACTION;
         min_reversals_ff  <= scd_pkg::RST_MIN_REVERSALS;
         travel_factor_ff  <= scd_pkg::RST_TRAVEL_FACTOR;
      end else if (csr_write) begin
         unique case (reg_sel)
            scd_pkg::REG_MIN_POINTS:     min_points_ff     <= pwdata[10:0];
            scd_pkg::REG_MIN_LONG_SIDE:  min_long_side_ff  <= pwdata[19:0];
            scd_pkg::REG_BLOB_RATIO:     blob_ratio_ff     <= pwdata[7:0];
            scd_pkg::REG_NOISE_FLOOR:    noise_floor_ff    <= pwdata[19:0];
            scd_pkg::REG_NOISE_FRACTION: noise_fraction_ff <= pwdata[7:0];
            scd_pkg::REG_MIN_REVERSALS:  min_reversals_ff  <= pwdata[9:0];
            scd_pkg::REG_TRAVEL_FACTOR:  travel_factor_ff  <= pwdata[11:0];
            default: ;                   // unmapped slot: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         scd_pkg::REG_MIN_POINTS:     prdata = 32'(min_points_ff);
         scd_pkg::REG_MIN_LONG_SIDE:  prdata = 32'(min_long_side_ff);
         scd_pkg::REG_BLOB_RATIO:     prdata = 32'(blob_ratio_ff);
         scd_pkg::REG_NOISE_FLOOR:    prdata = 32'(noise_floor_ff);
         scd_pkg::REG_NOISE_FRACTION: prdata = 32'(noise_fraction_ff);
         scd_pkg::REG_MIN_REVERSALS:  prdata = 32'(min_reversals_ff);
         scd_pkg::REG_TRAVEL_FACTOR:  prdata = 32'(travel_factor_ff);
         default:                     prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ sequencer
   scd_pkg::scd_state_type state_ff;
   scd_pkg::scd_mul_type   mul_step_ff;

   logic [CW-1:0]  count_ff;      // points stored this stroke
   logic           overflow_ff;
   logic [CW-1:0]  idx_ff;        // pass index, also memory read address
   logic           rsp_valid_ff;

   logic           req_fire;
   logic           stroke_empty;
   logic           store_ok;

   assign req_chan.ready = (state_ff == scd_pkg::S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign stroke_empty   = (count_ff == '0) && !overflow_ff;
   assign store_ok       = (count_ff < CAP);

   // ---------------------------------------------------------- point store
   // x in the upper half, y in the lower half of each word
   logic [scd_pkg::POINT_W-1:0] mem [MAX_POINTS];
   logic [scd_pkg::POINT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req_fire && store_ok) begin
         mem[count_ff[AW-1:0]] <= {req_chan.x_coord, req_chan.y_coord};
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   // ------------------------------------------------------------ datapath
   logic signed [19:0] box_min_x_ff, box_max_x_ff, box_min_y_ff, box_max_y_ff;
   logic [19:0]        long_ff, short_ff;
   logic               horiz_ff;
   logic [scd_pkg::THR_W-1:0]   blob_thr_ff, noise_thr_ff;
   logic [scd_pkg::MUL_P_W-1:0] trav_thr_ff;

   logic signed [19:0] anchor_ff, prev_ff, vcur_ff;
   logic [19:0]        adist_ff;       // |v - anchor|
   logic [19:0]        astep_ff;       // |v - prev|
   logic               dpos_ff;        // v above anchor
   logic               dir_valid_ff, dir_pos_ff;
   logic [TW-1:0]      travel_ff;
   logic [9:0]         revs_ff;
   logic               reject_ff;

   logic                 rsp_scribble_ff, rsp_overflow_ff;
   logic [9:0]           rsp_revs_ff;

   // box extent: max - min is never negative, so the low 20 bits carry it
   logic signed [20:0] width_w, height_w;
   assign width_w  = 21'(box_max_x_ff) - 21'(box_min_x_ff);
   assign height_w = 21'(box_max_y_ff) - 21'(box_min_y_ff);

   // shared multiplier: long side times one of three ratios
   logic [scd_pkg::MUL_B_W-1:0] mul_b;
   logic [scd_pkg::MUL_P_W-1:0] mul_p;
   always_comb begin
      unique case (mul_step_ff)
         scd_pkg::MUL_BLOB:   mul_b = 12'(blob_ratio_ff);
         scd_pkg::MUL_NOISE:  mul_b = 12'(noise_fraction_ff);
         scd_pkg::MUL_TRAVEL: mul_b = travel_factor_ff;
         default:             mul_b = '0;
      endcase
   end
   assign mul_p = scd_pkg::MUL_P_W'(long_ff) * scd_pkg::MUL_P_W'(mul_b);

   // early rejection
   logic early_reject;
   assign early_reject = overflow_ff
                      || (CMPW'(count_ff) < CMPW'(min_points_ff))
                      || (count_ff == '0)
                      || (long_ff < min_long_side_ff)
                      || ({short_ff, 8'd0} > blob_thr_ff);

   // value on the long axis from the store word
   logic signed [19:0] vsel;
   assign vsel = horiz_ff ? rdata_ff[39:20] : rdata_ff[19:0];

   logic signed [20:0] d_anchor, d_prev;
   assign d_anchor = 21'(vsel) - 21'(anchor_ff);
   assign d_prev   = 21'(vsel) - 21'(prev_ff);

   logic is_noise;
   assign is_noise = (adist_ff < noise_floor_ff) || ({adist_ff, 8'd0} < noise_thr_ff);

   logic travel_ok, verdict;
   assign travel_ok = {travel_ff, 8'd0} > TCW'(trav_thr_ff);
   assign verdict   = !reject_ff && (revs_ff >= min_reversals_ff) && travel_ok;

   logic final_load;
   assign final_load = (state_ff == scd_pkg::S_FINAL) && (!rsp_valid_ff || rsp_chan.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scd_pkg::S_IDLE;
         mul_step_ff  <= scd_pkg::MUL_BLOB;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !final_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            scd_pkg::S_IDLE: begin
               if (req_fire) begin
                  if (store_ok) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_chan.last_point) begin
                     idx_ff   <= '0;
                     state_ff <= scd_pkg::S_BOX;
                  end
               end
            end
            scd_pkg::S_BOX: begin
               mul_step_ff <= scd_pkg::MUL_BLOB;
               state_ff    <= scd_pkg::S_MUL;
            end
            scd_pkg::S_MUL: begin
               unique case (mul_step_ff)
                  scd_pkg::MUL_BLOB:   mul_step_ff <= scd_pkg::MUL_NOISE;
                  scd_pkg::MUL_NOISE:  mul_step_ff <= scd_pkg::MUL_TRAVEL;
                  default:             state_ff    <= scd_pkg::S_CHECK;
               endcase
            end
            scd_pkg::S_CHECK: begin
               idx_ff <= CW'(1);
               if (early_reject || count_ff == CW'(1)) begin
                  state_ff <= scd_pkg::S_FINAL;
               end else begin
                  state_ff <= scd_pkg::S_FETCH;
               end
            end
            scd_pkg::S_FETCH: state_ff <= scd_pkg::S_DIFF;
            scd_pkg::S_DIFF: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= scd_pkg::S_UPD;
            end
            scd_pkg::S_UPD: begin
               state_ff <= (idx_ff == count_ff) ? scd_pkg::S_FINAL : scd_pkg::S_DIFF;
            end
            scd_pkg::S_FINAL: begin
               if (final_load) begin
                  rsp_valid_ff <= 1'b1;
                  count_ff     <= '0;
                  overflow_ff  <= 1'b0;
                  state_ff     <= scd_pkg::S_IDLE;
               end
            end
            default: state_ff <= scd_pkg::S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (stroke_empty) begin
            box_min_x_ff <= req_chan.x_coord;
            box_max_x_ff <= req_chan.x_coord;
            box_min_y_ff <= req_chan.y_coord;
            box_max_y_ff <= req_chan.y_coord;
         end else begin
            if (req_chan.x_coord < box_min_x_ff) box_min_x_ff <= req_chan.x_coord;
            if (req_chan.x_coord > box_max_x_ff) box_max_x_ff <= req_chan.x_coord;
            if (req_chan.y_coord < box_min_y_ff) box_min_y_ff <= req_chan.y_coord;
            if (req_chan.y_coord > box_max_y_ff) box_max_y_ff <= req_chan.y_coord;
         end
      end

      unique case (state_ff)
         scd_pkg::S_BOX: begin
            horiz_ff <= (width_w >= height_w);
            long_ff  <= (width_w >= height_w) ? width_w[19:0] : height_w[19:0];
            short_ff <= (width_w >= height_w) ? height_w[19:0] : width_w[19:0];
         end
         scd_pkg::S_MUL: begin
            unique case (mul_step_ff)
               scd_pkg::MUL_BLOB:   blob_thr_ff  <= mul_p[scd_pkg::THR_W-1:0];
               scd_pkg::MUL_NOISE:  noise_thr_ff <= mul_p[scd_pkg::THR_W-1:0];
               default:             trav_thr_ff  <= mul_p;
            endcase
         end
         scd_pkg::S_CHECK: begin
            // first stored point is the opening anchor
            anchor_ff    <= vsel;
            prev_ff      <= vsel;
            travel_ff    <= '0;
            dir_valid_ff <= 1'b0;
            dir_pos_ff   <= 1'b0;
            revs_ff      <= '0;
            reject_ff    <= early_reject;
         end
         scd_pkg::S_DIFF: begin
            adist_ff <= d_anchor[20] ? 20'(-d_anchor) : d_anchor[19:0];
            astep_ff <= d_prev[20] ? 20'(-d_prev) : d_prev[19:0];
            dpos_ff  <= !d_anchor[20] && (d_anchor != '0);
            vcur_ff  <= vsel;
            prev_ff  <= vsel;
         end
         scd_pkg::S_UPD: begin
            travel_ff <= travel_ff + TW'(astep_ff);
            if (!is_noise) begin
               if (dir_valid_ff && (dpos_ff != dir_pos_ff) && (revs_ff < scd_pkg::REVS_MAX)) begin
                  revs_ff <= revs_ff + 1'b1;
               end
               dir_valid_ff <= 1'b1;
               dir_pos_ff   <= dpos_ff;
               anchor_ff    <= vcur_ff;
            end
         end
         default: ;
      endcase

      if (final_load) begin
         rsp_scribble_ff <= verdict;
         rsp_revs_ff     <= reject_ff ? '0 : revs_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.is_scribble    = rsp_scribble_ff;
   assign rsp_chan.reversal_count = rsp_revs_ff;
   assign rsp_chan.overflow       = rsp_overflow_ff;

`ifndef ASSERT_OFF
   // a verdict is only ever launched from the final state
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == scd_pkg::S_FINAL))
      else $error("response raised outside final state");

   // an overflowed stroke is rejected before the pass
   a_overflow_rejects: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overflow |->
         !rsp_chan.is_scribble && (rsp_chan.reversal_count == '0))
      else $error("overflowed stroke not rejected");

   // stored count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("point count beyond capacity");

   // a positive verdict carries enough reversals
   a_scribble_revs: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_scribble |->
         rsp_chan.reversal_count >= min_reversals_ff)
      else $error("scribble verdict with too few reversals");
`endif

endmodule

@@ tb/sv/scribble_crossout_detector_tb.sv @@
// Self-checking testbench for the scribble cross-out detector.
`timescale 1ns / 1ps

module scribble_crossout_detector_tb;

   localparam int MAX_PTS         = 1024;
   localparam int NUM_PHASES      = 14;
   localparam int PHASE_POINTS    = 16;    // random requests per setting phase
   localparam int BIG_PHASE       = 2;     // phase that carries the overrunning stroke
   localparam int HOLD_PHASE      = 4;     // phase in which the receiver holds off
   localparam int HOLD_STROKES    = 4;     // enough strokes to back the block up
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 24;    // time for a rejected verdict, with margin
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic       is_scribble;
      logic [9:0] reversal_count;
      logic       overflow;
   } verdict_type;

   // one row of the directed table; typed rows carry their own verdict
   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic               last;
      logic               typed;
      verdict_type        v;
   } pen_row_type;

   localparam verdict_type V_REJECT = '{1'b0, 10'd0, 1'b0};
   localparam verdict_type V_NONE   = '0;

   localparam scd_pkg::scd_reg_type ALL_REGS [7] = '{
      scd_pkg::REG_MIN_POINTS, scd_pkg::REG_MIN_LONG_SIDE, scd_pkg::REG_BLOB_RATIO,
      scd_pkg::REG_NOISE_FLOOR, scd_pkg::REG_NOISE_FRACTION, scd_pkg::REG_MIN_REVERSALS,
      scd_pkg::REG_TRAVEL_FACTOR};

   // Directed strokes, all under the reset thresholds:
   //  - a lone point (too few points, rejected early)
   //  - the corners of the coordinate range, both diagonals (too few points)
   //  - a clean twelve-point horizontal zig-zag, which the predictor judges
   localparam int TABLE_ROWS = 17;
   localparam pen_row_type PEN_TABLE [TABLE_ROWS] = '{
      '{20'sd0,       20'sd0,       1'b1, 1'b1, V_REJECT},
      '{20'h80000,    20'h80000,    1'b0, 1'b0, V_NONE},
      '{20'h7FFFF,    20'h7FFFF,    1'b1, 1'b1, V_REJECT},
      '{20'h7FFFF,    20'h80000,    1'b0, 1'b0, V_NONE},
      '{20'h80000,    20'h7FFFF,    1'b1, 1'b1, V_REJECT},
      '{20'sd0,       20'sd0,       1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd10,      1'b0, 1'b0, V_NONE},
      '{20'sd0,       20'sd20,      1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd30,      1'b0, 1'b0, V_NONE},
      '{20'sd0,       20'sd40,      1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd50,      1'b0, 1'b0, V_NONE},
      '{20'sd0,       20'sd60,      1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd70,      1'b0, 1'b0, V_NONE},
      '{20'sd0,       20'sd80,      1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd90,      1'b0, 1'b0, V_NONE},
      '{20'sd0,       20'sd100,     1'b0, 1'b0, V_NONE},
      '{20'sd1600,    20'sd110,     1'b1, 1'b0, V_NONE}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [scd_pkg::ADDR_W-1:0] paddr;
   logic [scd_pkg::DATA_W-1:0] pwdata;
   logic [scd_pkg::DATA_W-1:0] prdata;
   logic        pready;

   scd_req_if req_chan ();
   scd_rsp_if rsp_chan ();

   scribble_crossout_detector #(.MAX_POINTS(MAX_PTS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor state: shadow thresholds, point store and bounding box
   // ---------------------------------------------------------------------
   logic [10:0] th_min_points     = scd_pkg::RST_MIN_POINTS;
   logic [19:0] th_min_long_side  = scd_pkg::RST_MIN_LONG_SIDE;
   logic [7:0]  th_blob_ratio     = scd_pkg::RST_BLOB_RATIO;
   logic [19:0] th_noise_floor    = scd_pkg::RST_NOISE_FLOOR;
   logic [7:0]  th_noise_fraction = scd_pkg::RST_NOISE_FRACTION;
   logic [9:0]  th_min_reversals  = scd_pkg::RST_MIN_REVERSALS;
   logic [11:0] th_travel_factor  = scd_pkg::RST_TRAVEL_FACTOR;

   int pt_x [MAX_PTS];
   int pt_y [MAX_PTS];
   int pt_count    = 0;
   bit pt_overflow = 1'b0;
   int bmin_x = 0, bmax_x = 0, bmin_y = 0, bmax_y = 0;

   verdict_type verdicts_due [$];

   // run statistics and failure count
   int mismatches       = 0;
   int verdicts_checked = 0;
   int points_taken     = 0;
   int scribbles_due    = 0;
   int overflows_due    = 0;
   int settings_applied = 0;
   int hold_offs_done   = 0;

   // handshake pacing, changed per phase by the stimulus
   int rsp_gap_pct = 0;
   int req_gap_pct = 0;
   int rsp_stall_left;
   bit hold_off_armed = 1'b0;

   // verdict typed into the directed table travels with its request
   logic        row_typed;
   verdict_type row_verdict;

   // stroke under construction for the random part
   int stroke_x [$];
   int stroke_y [$];

   function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   // Verdict for the stroke held in the store: early rejects first, then
   // the pass along the long axis summing travel and counting reversals.
   function automatic verdict_type judge_stroke();
      longint w, h, lng, sht, anchor, prev, v, d, ad, travel;
      longint mls, blob, nfl, nfr, mrev, tfac;
      bit horiz;
      int dir, nd, i;
      int revs;
      verdict_type r;
      r = '0;
      r.overflow = pt_overflow;
      mls  = th_min_long_side;
      blob = th_blob_ratio;
      nfl  = th_noise_floor;
      nfr  = th_noise_fraction;
      mrev = th_min_reversals;
      tfac = th_travel_factor;
      w = longint'(bmax_x) - longint'(bmin_x);
      h = longint'(bmax_y) - longint'(bmin_y);
      horiz = (w >= h);
      lng = horiz ? w : h;
      sht = horiz ? h : w;
      if (pt_overflow || pt_count < int'(th_min_points) || pt_count == 0) return r;
      if (lng < mls) return r;
      if (sht * 256 > lng * blob) return r;
      anchor = horiz ? pt_x[0] : pt_y[0];
      prev   = anchor;
      travel = 0;
      dir    = 0;
      revs   = 0;
      for (i = 1; i < pt_count; i++) begin
         v  = horiz ? pt_x[i] : pt_y[i];
         d  = v - anchor;
         ad = (d < 0) ? -d : d;
         travel += (v < prev) ? prev - v : v - prev;
         prev = v;
         // moves inside the jitter limit leave the anchor where it is
         if (ad < nfl || ad * 256 < lng * nfr) continue;
         nd = (d > 0) ? 1 : -1;
         if (dir != 0 && nd != dir && revs < 1023) revs++;
         dir    = nd;
         anchor = v;
      end
      r.reversal_count = revs[9:0];
      r.is_scribble = (revs >= mrev) && (travel * 256 > lng * tfac);
      return r;
   endfunction

   function automatic void take_point(int x, int y, logic last, logic typed, verdict_type tv);
      verdict_type r;
      points_taken++;
      if (pt_count == 0 && !pt_overflow) begin
         bmin_x = x; bmax_x = x; bmin_y = y; bmax_y = y;
      end else begin
         if (x < bmin_x) bmin_x = x;
         if (x > bmax_x) bmax_x = x;
         if (y < bmin_y) bmin_y = y;
         if (y > bmax_y) bmax_y = y;
      end
      // points past the store still stretch the box
      if (pt_count < MAX_PTS) begin
         pt_x[pt_count] = x;
         pt_y[pt_count] = y;
         pt_count++;
      end else begin
         pt_overflow = 1'b1;
      end
      if (last) begin
         r = typed ? tv : judge_stroke();
         verdicts_due.push_back(r);
         if (r.is_scribble) scribbles_due++;
         if (r.overflow) overflows_due++;
         pt_count = 0;
         pt_overflow = 1'b0;
         bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0;
      end
   endfunction

   function automatic void check_verdict();
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         report_mismatch("verdict with no stroke pending", 0, 1);
         return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      if (rsp_chan.is_scribble !== want.is_scribble)
         report_mismatch("is_scribble", want.is_scribble, rsp_chan.is_scribble);
      if (rsp_chan.reversal_count !== want.reversal_count)
         report_mismatch("reversal_count", want.reversal_count, rsp_chan.reversal_count);
      if (rsp_chan.overflow !== want.overflow)
         report_mismatch("overflow", want.overflow, rsp_chan.overflow);
   endfunction

   // Both channels are watched on the same edge; the verdict is checked
   // first so a request completing a stroke cannot mask a stray verdict.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) check_verdict();
         if (req_chan.valid && req_chan.ready)
            take_point(int'(req_chan.x_coord), int'(req_chan.y_coord), req_chan.last_point,
                       row_typed, row_verdict);
      end
   end

   // Receiver: random stall bursts, plus one long hold-off
   // during which the sender keeps offering requests and the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (hold_off_armed) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= HOLD_OFF_CYCLES - 1;
         hold_off_armed <= 1'b0;
         hold_offs_done <= hold_offs_done + 1;
      end else if (rsp_gap_pct != 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int spread(int m);
      int r;
      r = $urandom_range(0, 2 * m);
      return r - m;
   endfunction

   function automatic int clamp20(int v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   // One request; valid stays up between back-to-back requests and only
   // drops for an idle burst.
   task automatic send_point(int x, int y, logic last, logic typed, verdict_type tv);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.x_coord    <= x[19:0];
      req_chan.y_coord    <= y[19:0];
      req_chan.last_point <= last;
      row_typed           <= typed;
      row_verdict         <= tv;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_stroke();
      int k;
      for (k = 0; k < stroke_x.size(); k++)
         send_point(stroke_x[k], stroke_y[k], k == stroke_x.size() - 1, 1'b0, V_NONE);
   endtask

   task automatic add_point(int x, int y);
      stroke_x.push_back(clamp20(x));
      stroke_y.push_back(clamp20(y));
   endtask

   // Zig-zag across a band, with repeats, small jitter moves and now and
   // then a huge span that runs into the edges of the coordinate range.
   task automatic make_scribble(int n);
      int span, band, c_al, c_cr, al, cr, k, off;
      bit horiz, side;
      span  = ($urandom_range(0, 9) == 0) ? $urandom_range(4000, 1000000)
                                          : $urandom_range(60, 4000);
      band  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, span);
      horiz = $urandom_range(0, 1);
      c_al  = spread(400000);
      c_cr  = spread(400000);
      side  = 1'b0;
      al    = c_al;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 7))
            0: ;                                // same spot again
            1: al = al + spread(span / 16);     // jitter near the last turn
            default: begin
               side = !side;
               al = c_al + (side ? span / 2 : -(span / 2)) + spread(span / 8);
            end
         endcase
         off = $urandom_range(0, band);
         cr  = c_cr + off;
         if (horiz) add_point(al, cr);
         else add_point(cr, al);
      end
   endtask

   task automatic make_random_stroke();
      int n, k, c_al, c_cr, step, kind;
      bit horiz;
      stroke_x.delete();
      stroke_y.delete();
      kind  = $urandom_range(0, 9);
      horiz = $urandom_range(0, 1);
      c_al  = spread(400000);
      c_cr  = spread(400000);
      case (kind)
         6: begin  // straight line, no turns
            n = $urandom_range(2, 30);
            step = spread(3000);
            for (k = 0; k < n; k++) begin
               if (horiz) add_point(c_al + k * step, c_cr + spread(50));
               else add_point(c_cr + spread(50), c_al + k * step);
            end
         end
         7, 9: begin  // points anywhere in the range
            n = (kind == 9) ? $urandom_range(1, 3) : $urandom_range(1, 25);
            for (k = 0; k < n; k++)
               add_point(spread(524288) - ($urandom_range(0, 1)),
                         spread(524288) - ($urandom_range(0, 1)));
         end
         8: begin  // tight blob of jitter
            n = $urandom_range(1, 30);
            for (k = 0; k < n; k++) add_point(c_al + spread(80), c_cr + spread(80));
         end
         default: make_scribble($urandom_range(4, 40));
      endcase
   endtask

   // APB transfer: setup phase, access phase, then an idle phase
   task automatic csr_access(scd_pkg::scd_reg_type idx, logic wr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] reg_value(scd_pkg::scd_reg_type idx);
      case (idx)
         scd_pkg::REG_MIN_POINTS:     return 32'(th_min_points);
         scd_pkg::REG_MIN_LONG_SIDE:  return 32'(th_min_long_side);
         scd_pkg::REG_BLOB_RATIO:     return 32'(th_blob_ratio);
         scd_pkg::REG_NOISE_FLOOR:    return 32'(th_noise_floor);
         scd_pkg::REG_NOISE_FRACTION: return 32'(th_noise_fraction);
         scd_pkg::REG_MIN_REVERSALS:  return 32'(th_min_reversals);
         scd_pkg::REG_TRAVEL_FACTOR:  return 32'(th_travel_factor);
         default:                     return '0;
      endcase
   endfunction

   task automatic read_check(scd_pkg::scd_reg_type idx);
      logic [31:0] got;
      csr_access(idx, 1'b0, '0, got);
      if (got !== reg_value(idx)) report_mismatch("register readback", reg_value(idx), got);
   endtask

   task automatic set_reg(scd_pkg::scd_reg_type idx, logic [31:0] val);
      logic [31:0] dummy;
      case (idx)
         scd_pkg::REG_MIN_POINTS:     th_min_points     = val[10:0];
         scd_pkg::REG_MIN_LONG_SIDE:  th_min_long_side  = val[19:0];
         scd_pkg::REG_BLOB_RATIO:     th_blob_ratio     = val[7:0];
         scd_pkg::REG_NOISE_FLOOR:    th_noise_floor    = val[19:0];
         scd_pkg::REG_NOISE_FRACTION: th_noise_fraction = val[7:0];
         scd_pkg::REG_MIN_REVERSALS:  th_min_reversals  = val[9:0];
         scd_pkg::REG_TRAVEL_FACTOR:  th_travel_factor  = val[11:0];
         default: ;
      endcase
      csr_access(idx, 1'b1, val, dummy);
      read_check(idx);
   endtask

   // Wait for every verdict owed, then let the sequencer settle. Starts on
   // an edge so the request just accepted has reached the predictor.
   task automatic drain_verdicts();
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int ph, r, k, phase_start, phase_strokes;
      logic [31:0] vals [7];

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.x_coord    = '0;
      req_chan.y_coord    = '0;
      req_chan.last_point = 1'b0;
      rsp_chan.ready      = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      row_typed   = 1'b0;
      row_verdict = V_NONE;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // thresholds must come out of reset at their defaults
      for (r = 0; r < 7; r++) read_check(ALL_REGS[r]);

      // directed strokes under the reset thresholds
      req_gap_pct = 20;
      rsp_gap_pct = 10;
      for (r = 0; r < TABLE_ROWS; r++)
         send_point(PEN_TABLE[r].x, PEN_TABLE[r].y, PEN_TABLE[r].last,
                    PEN_TABLE[r].typed, PEN_TABLE[r].v);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         req_chan.valid <= 1'b0;
         drain_verdicts();

         // thresholds: all zero, all at maximum, then mostly moderate values
         // that let real scribbles through, now and then anything at all
         if (ph == 0) begin
            for (r = 0; r < 7; r++) vals[r] = 0;
         end else if (ph == 1) begin
            vals = '{1024, 1048575, 255, 1048575, 255, 1023, 4095};
         end else if ($urandom_range(0, 4) == 0 && ph != BIG_PHASE) begin
            vals = '{$urandom_range(0, 1024), $urandom_range(0, 1048575),
                     $urandom_range(0, 255), $urandom_range(0, 1048575),
                     $urandom_range(0, 255), $urandom_range(0, 1023),
                     $urandom_range(0, 4095)};
         end else begin
            vals = '{$urandom_range(0, 20), $urandom_range(0, 3000),
                     $urandom_range(40, 255), $urandom_range(0, 300),
                     $urandom_range(0, 40), $urandom_range(0, 8),
                     $urandom_range(0, 1500)};
         end
         for (r = 0; r < 7; r++) set_reg(ALL_REGS[r], vals[r]);
         settings_applied++;

         // pacing: none in the closing phases, none from the sender while
         // the receiver holds off so the block fills up
         if (ph >= NUM_PHASES - 2) begin
            req_gap_pct = 0;
            rsp_gap_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: begin req_gap_pct = 0;  rsp_gap_pct = 0;  end
               1: begin req_gap_pct = 10; rsp_gap_pct = 5;  end
               2: begin req_gap_pct = 30; rsp_gap_pct = 15; end
               default: begin req_gap_pct = 60; rsp_gap_pct = 40; end
            endcase
         end
         if (ph == HOLD_PHASE) begin
            req_gap_pct = 0;
            hold_off_armed <= 1'b1;
         end

         // a stroke that fills the store and runs past it
         if (ph == BIG_PHASE) begin
            stroke_x.delete();
            stroke_y.delete();
            make_scribble(MAX_PTS);
            // overrun points still widen the box
            for (k = 0; k < 3; k++) add_point(spread(524288), spread(524288));
            send_stroke();
         end

         phase_start   = points_taken;
         phase_strokes = 0;
         while (points_taken - phase_start < PHASE_POINTS
                || (ph == HOLD_PHASE && phase_strokes < HOLD_STROKES)) begin
            make_random_stroke();
            send_stroke();
            phase_strokes++;
         end
      end

      req_chan.valid <= 1'b0;
      drain_verdicts();

      $display("Checked %0d verdicts from %0d pen points over %0d threshold settings",
               verdicts_checked, points_taken, settings_applied + 1);
      $display("Strokes judged scribbles: %0d, overrun strokes: %0d, receiver hold-offs: %0d",
               scribbles_due, overflows_due, hold_offs_done);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/scd_pkg.sv
sv/scd_req_if.sv
sv/scd_rsp_if.sv
sv/scribble_crossout_detector.sv
tb/sv/scribble_crossout_detector_tb.sv
